>>> rtl/core/c2tdg_pkg.sv
// Shared constants, types and fixed-point helpers of the chi2 track distance gate.
package c2tdg_pkg;

   localparam int NUM_PARAMS = 5;
   localparam int NUM_COV    = NUM_PARAMS * (NUM_PARAMS + 1) / 2;
   localparam int NUM_ELEMS  = 2 * NUM_PARAMS + NUM_COV;
   localparam int IDX_W      = $clog2(NUM_PARAMS + 1);
   localparam int ADDR_W     = $clog2(NUM_ELEMS);
   localparam int WL_DEPTH   = NUM_PARAMS * NUM_PARAMS;
   localparam int WL_ADDR_W  = $clog2(WL_DEPTH);
   localparam int DIV_STEPS  = 64;

   localparam logic [31:0] CUT_RESET = 32'd1638400000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_C_INIT,
      ST_C_LOAD,
      ST_C_RD,
      ST_C_MUL,
      ST_C_SUB,
      ST_C_CHECK,
      ST_L_RD,
      ST_L_DIV,
      ST_L_WAIT,
      ST_Y_RD0,
      ST_Y_RD1,
      ST_Y_DIFF,
      ST_Y_LRD,
      ST_Y_MUL,
      ST_Y_SUB,
      ST_Y_SQ,
      ST_Y_DIV,
      ST_Y_WAIT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x > 33'sh0_7FFF_FFFF)      r = 32'sh7FFF_FFFF;
      else if (x < -33'sh0_8000_0000) r = 32'sh8000_0000;
      else                            r = x[31:0];
      return r;
   endfunction

   // Product scaled back by 2^16, truncated toward zero, saturated.
   function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
      logic signed [63:0] adj;
      logic signed [47:0] q;
      logic signed [31:0] r;
      adj = p + (p[63] ? 64'sd65535 : 64'sd0);
      q   = adj[63:16];
      if (q > 48'sh0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
      else if (q < -48'sh0000_8000_0000) r = 32'sh8000_0000;
      else                                r = q[31:0];
      return r;
   endfunction

   function automatic logic [WL_ADDR_W-1:0] wl_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
      logic [WL_ADDR_W+IDX_W-1:0] a;
      a = WL_ADDR_W'(NUM_PARAMS) * r + c;
      return a[WL_ADDR_W-1:0];
   endfunction

   // Upper-triangle slot of covariance element (r, c), r <= c.
   function automatic logic [ADDR_W-1:0] cov_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      logic [ADDR_W+IDX_W-1:0] rr;
      logic [ADDR_W+IDX_W-1:0] tri_sz;
      logic [ADDR_W+IDX_W-1:0] a;
      rr     = (ADDR_W+IDX_W)'(r);
      tri_sz = (rr * (rr - 1'b1)) >> 1;
      a      = (ADDR_W+IDX_W)'(2 * NUM_PARAMS) + rr * (ADDR_W+IDX_W)'(NUM_PARAMS)
               - tri_sz + (ADDR_W+IDX_W)'(c) - rr;
      return a[ADDR_W-1:0];
   endfunction

endpackage

>>> rtl/core/c2tdg_div.sv
// Restoring radix-2 divider, 64-bit unsigned dividend by 32-bit divisor.
module c2tdg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  c2tdg_pkg::div_req_type req,
   output c2tdg_pkg::div_rsp_type rsp
);

   logic [63:0] quo_ff,  quo_in;
   logic [31:0] rem_ff,  rem_in;
   logic [31:0] dvs_ff,  dvs_in;
   logic [6:0]  cnt_ff,  cnt_in;
   logic        run_ff,  run_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic        qbit;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[63]};
      qbit    = (rem_sh >= {1'b0, dvs_ff});
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = qbit ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         quo_in = {quo_ff[62:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 7'(c2tdg_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> rtl/core/chi2_track_distance_gate_core.sv
// Top level of the chi2 track distance gate: element store, LDL sequencer, result port.
//
// Use: load the two parameter vectors and the covariance upper triangle, one
// element per beat on req_* while start is high and busy is low. A beat with
// req_element_index beyond the store writes nothing. A beat with
// req_last_element set stores its element and then starts the computation;
// busy stays high until the result appears.
// Loading takes one element per cycle while busy is low. A computation that
// factors keeps busy high after the last beat mostly for fifteen passes
// through the shared 64-step divider (ten for the L factor, five for the
// chi2 terms), plus the multiply-accumulate steps through the multiplier and
// the registered reads of the element and factor memories. A singular matrix
// ends at its first non-positive pivot.
// The result appears on rsp_* for one cycle, marked by rsp_valid, in the first
// cycle in which busy is low again; there is no back-pressure and a new set
// may load at once.
// csr_* writes the chi2 cut (unsigned Q16.16); csr_ready is always high.
// Reset returns the sequencer to idle and the cut to 25000.0; the element
// store keeps no reset value and must be loaded before use.
module chi2_track_distance_gate_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [4:0]         req_element_index,
   input  logic signed [31:0] req_element_value,
   input  logic               req_last_element,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [31:0]        rsp_chi2_value,
   output logic               rsp_within_cut,
   output logic               rsp_singular_matrix
);

   localparam int N  = c2tdg_pkg::NUM_PARAMS;
   localparam int IW = c2tdg_pkg::IDX_W;

   c2tdg_pkg::state_type state_ff, state_in;

   logic [IW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] rec_ff, rec_in;
   logic               neg_ff, neg_in;
   logic [31:0]        chi2_ff, chi2_in;
   logic [31:0]        cut_ff;
   logic signed [31:0] dg_ff [N];
   logic signed [31:0] dg_in [N];
   logic signed [31:0] y_ff  [N];
   logic signed [31:0] y_in  [N];
   logic               rv_ff, rv_in;
   logic [31:0]        rchi_ff, rchi_in;
   logic               rcut_ff, rcut_in;
   logic               rsing_ff, rsing_in;

   logic signed [31:0] store_mem [c2tdg_pkg::NUM_ELEMS];
   logic signed [31:0] store_rd_ff;
   logic [c2tdg_pkg::ADDR_W-1:0] store_raddr;

   logic signed [31:0] w_mem [c2tdg_pkg::WL_DEPTH];
   logic signed [31:0] l_mem [c2tdg_pkg::WL_DEPTH];
   logic signed [31:0] w_rd_ff, l_rd_ff;
   logic [c2tdg_pkg::WL_ADDR_W-1:0] w_raddr, l_raddr, w_waddr, l_waddr;
   logic               w_we, l_we;
   logic signed [31:0] w_wdata, l_wdata;

   logic signed [31:0] mul_a, mul_b;
   logic [IW-1:0]      dg_idx;
   logic signed [31:0] dg_sel;
   logic [31:0]        w_abs;
   logic [63:0]        q;
   logic [32:0]        sum33;
   logic               accept;

   c2tdg_pkg::div_req_type div_req;
   c2tdg_pkg::div_rsp_type div_rsp;

   c2tdg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != c2tdg_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Element store: one write port from the request channel, one read port.
   always_ff @(posedge clock) begin
      if (accept && (req_element_index < 5'(c2tdg_pkg::NUM_ELEMS)))
         store_mem[req_element_index[c2tdg_pkg::ADDR_W-1:0]] <= req_element_value;
      store_rd_ff <= store_mem[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (w_we) w_mem[w_waddr] <= w_wdata;
      w_rd_ff <= w_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (l_we) l_mem[l_waddr] <= l_wdata;
      l_rd_ff <= l_mem[l_raddr];
   end

   assign dg_sel = dg_ff[dg_idx];
   assign q      = div_rsp.quotient;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rec_in   = rec_ff;
      neg_in   = neg_ff;
      chi2_in  = chi2_ff;
      dg_in    = dg_ff;
      y_in     = y_ff;
      rv_in    = 1'b0;
      rchi_in  = rchi_ff;
      rcut_in  = rcut_ff;
      rsing_in = rsing_ff;

      store_raddr = c2tdg_pkg::cov_addr(j_ff, i_ff);
      w_raddr     = c2tdg_pkg::wl_addr(i_ff, k_ff);
      l_raddr     = c2tdg_pkg::wl_addr(j_ff, k_ff);
      w_waddr     = c2tdg_pkg::wl_addr(i_ff, j_ff);
      l_waddr     = c2tdg_pkg::wl_addr(i_ff, j_ff);
      w_we        = 1'b0;
      l_we        = 1'b0;
      w_wdata     = acc_ff;
      l_wdata     = '0;
      mul_a       = w_rd_ff;
      mul_b       = l_rd_ff;
      dg_idx      = j_ff;
      w_abs       = w_rd_ff[31] ? 32'(-w_rd_ff) : w_rd_ff;
      sum33       = {1'b0, chi2_ff} + ((q > 64'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, q[31:0]});
      div_req     = '0;

      unique case (state_ff)
         c2tdg_pkg::ST_IDLE: begin
            if (accept && req_last_element) begin
               i_in     = '0;
               j_in     = '0;
               state_in = c2tdg_pkg::ST_C_INIT;
            end
         end
         c2tdg_pkg::ST_C_INIT: begin
            state_in = c2tdg_pkg::ST_C_LOAD;
         end
         c2tdg_pkg::ST_C_LOAD: begin
            acc_in   = store_rd_ff;
            k_in     = '0;
            state_in = (j_ff == '0) ? c2tdg_pkg::ST_C_CHECK : c2tdg_pkg::ST_C_RD;
         end
         c2tdg_pkg::ST_C_RD: begin
            state_in = c2tdg_pkg::ST_C_MUL;
         end
         c2tdg_pkg::ST_C_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = c2tdg_pkg::ST_C_SUB;
         end
         c2tdg_pkg::ST_C_SUB: begin
            acc_in   = c2tdg_pkg::sat33(33'(acc_ff) - 33'(c2tdg_pkg::mulq(prod_ff)));
            k_in     = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == j_ff) ? c2tdg_pkg::ST_C_CHECK : c2tdg_pkg::ST_C_RD;
         end
         c2tdg_pkg::ST_C_CHECK: begin
            if (i_ff == j_ff) begin
               dg_in[j_ff] = acc_ff;
               if (acc_ff <= 32'sd0) begin
                  // non-positive pivot: report singular and stop
                  rv_in    = 1'b1;
                  rchi_in  = 32'hFFFF_FFFF;
                  rcut_in  = 1'b0;
                  rsing_in = 1'b1;
                  state_in = c2tdg_pkg::ST_IDLE;
               end
            end else begin
               w_we = 1'b1;
            end
            if (!(i_ff == j_ff && acc_ff <= 32'sd0)) begin
               if (i_ff == IW'(N - 1)) begin
                  i_in = j_ff + 1'b1;
                  if (j_ff == IW'(N - 1)) begin
                     i_in     = '0;
                     chi2_in  = '0;
                     state_in = c2tdg_pkg::ST_Y_RD0;
                  end else begin
                     state_in = c2tdg_pkg::ST_L_RD;
                  end
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = c2tdg_pkg::ST_C_INIT;
               end
            end
         end
         c2tdg_pkg::ST_L_RD: begin
            w_raddr  = c2tdg_pkg::wl_addr(i_ff, j_ff);
            state_in = c2tdg_pkg::ST_L_DIV;
         end
         c2tdg_pkg::ST_L_DIV: begin
            neg_in           = w_rd_ff[31];
            div_req.start    = 1'b1;
            div_req.dividend = {16'h0, w_abs, 16'h0};
            div_req.divisor  = dg_sel;
            state_in         = c2tdg_pkg::ST_L_WAIT;
         end
         c2tdg_pkg::ST_L_WAIT: begin
            if (div_rsp.done) begin
               if (neg_ff)
                  l_wdata = (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q[31:0]);
               else
                  l_wdata = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
               l_we = 1'b1;
               if (i_ff == IW'(N - 1)) begin
                  j_in     = j_ff + 1'b1;
                  i_in     = j_ff + 1'b1;
                  state_in = c2tdg_pkg::ST_C_INIT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = c2tdg_pkg::ST_L_RD;
               end
            end
         end
         c2tdg_pkg::ST_Y_RD0: begin
            store_raddr = c2tdg_pkg::ADDR_W'(i_ff);
            state_in    = c2tdg_pkg::ST_Y_RD1;
         end
         c2tdg_pkg::ST_Y_RD1: begin
            store_raddr = c2tdg_pkg::ADDR_W'(N) + c2tdg_pkg::ADDR_W'(i_ff);
            rec_in      = store_rd_ff;
            state_in    = c2tdg_pkg::ST_Y_DIFF;
         end
         c2tdg_pkg::ST_Y_DIFF: begin
            acc_in   = c2tdg_pkg::sat33(33'(store_rd_ff) - 33'(rec_ff));
            k_in     = '0;
            state_in = (i_ff == '0) ? c2tdg_pkg::ST_Y_SQ : c2tdg_pkg::ST_Y_LRD;
         end
         c2tdg_pkg::ST_Y_LRD: begin
            l_raddr  = c2tdg_pkg::wl_addr(i_ff, k_ff);
            state_in = c2tdg_pkg::ST_Y_MUL;
         end
         c2tdg_pkg::ST_Y_MUL: begin
            mul_a    = l_rd_ff;
            mul_b    = y_ff[k_ff];
            prod_in  = mul_a * mul_b;
            state_in = c2tdg_pkg::ST_Y_SUB;
         end
         c2tdg_pkg::ST_Y_SUB: begin
            acc_in   = c2tdg_pkg::sat33(33'(acc_ff) - 33'(c2tdg_pkg::mulq(prod_ff)));
            k_in     = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == i_ff) ? c2tdg_pkg::ST_Y_SQ : c2tdg_pkg::ST_Y_LRD;
         end
         c2tdg_pkg::ST_Y_SQ: begin
            y_in[i_ff] = acc_ff;
            mul_a      = acc_ff;
            mul_b      = acc_ff;
            prod_in    = mul_a * mul_b;
            state_in   = c2tdg_pkg::ST_Y_DIV;
         end
         c2tdg_pkg::ST_Y_DIV: begin
            dg_idx           = i_ff;
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = dg_sel;
            state_in         = c2tdg_pkg::ST_Y_WAIT;
         end
         c2tdg_pkg::ST_Y_WAIT: begin
            if (div_rsp.done) begin
               // saturate the term, then the running sum
               chi2_in = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
               if (i_ff == IW'(N - 1)) begin
                  rv_in    = 1'b1;
                  rchi_in  = chi2_in;
                  rcut_in  = (chi2_in < cut_ff);
                  rsing_in = 1'b0;
                  state_in = c2tdg_pkg::ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = c2tdg_pkg::ST_Y_RD0;
               end
            end
         end
         default: state_in = c2tdg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rec_ff   <= rec_in;
      neg_ff   <= neg_in;
      chi2_ff  <= chi2_in;
      dg_ff    <= dg_in;
      y_ff     <= y_in;
      rchi_ff  <= rchi_in;
      rcut_ff  <= rcut_in;
      rsing_ff <= rsing_in;
      if (reset) begin
         state_ff <= c2tdg_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         cut_ff   <= c2tdg_pkg::CUT_RESET;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (csr_valid && csr_ready) cut_ff <= csr_wdata;
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_chi2_value      = rchi_ff;
   assign rsp_within_cut      = rcut_ff;
   assign rsp_singular_matrix = rsing_ff;

endmodule
